@@ rtl/core/tmh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the threshold mask halftoner.
// No dependencies.
package tmh_pkg;

  localparam int unsigned MaskMaxWDef = 128;
  localparam int unsigned MaskMaxHDef = 128;
  localparam int unsigned MaxLineDef  = 16384;
  localparam int unsigned FrameLimit  = 16384;
  localparam int unsigned BitsPerByte = 8;

  localparam int unsigned RegAddrW = 4;

  localparam logic [1:0] RegMaskWidth   = 2'd0;
  localparam logic [1:0] RegMaskHeight  = 2'd1;
  localparam logic [1:0] RegLineWidth   = 2'd2;
  localparam logic [1:0] RegFrameHeight = 2'd3;

  typedef struct packed {
    logic [7:0]  mask_width;
    logic [7:0]  mask_height;
    logic [14:0] line_width;
    logic [14:0] frame_height;
  } tmh_cfg_t;

  function automatic logic [7:0] bit_weight(input logic [2:0] idx);
    logic [7:0] w;
    case (idx)
      3'd0: w = 8'd128;
      3'd1: w = 8'd64;
      3'd2: w = 8'd32;
      3'd3: w = 8'd16;
      3'd4: w = 8'd8;
      3'd5: w = 8'd4;
      3'd6: w = 8'd2;
      3'd7: w = 8'd1;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/tmh_pix_if.sv @@
`timescale 1ns / 1ps
// Input channel of the halftoner: pixels and mask writes.
// No dependencies.
interface tmh_pix_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] pixel;
  logic [6:0] mask_row;
  logic [6:0] mask_col;
  logic [7:0] mask_value;

  modport source (output valid, action, pixel, mask_row, mask_col, mask_value, input ready);
  modport sink (input valid, action, pixel, mask_row, mask_col, mask_value, output ready);
endinterface

@@ rtl/core/tmh_byte_if.sv @@
`timescale 1ns / 1ps
// Output channel of the halftoner: packed bytes with line and frame flags.
// No dependencies.
interface tmh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_bits;
  logic       line_end;
  logic       frame_end;

  modport source (output valid, packed_bits, line_end, frame_end, input ready);
  modport sink (input valid, packed_bits, line_end, frame_end, output ready);
endinterface

@@ rtl/core/tmh_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tmh_regs.sv @@
`timescale 1ns / 1ps
// APB register file of the halftoner, with saturation of written values.
// Depends on tmh_pkg.
module tmh_regs #(
  parameter int unsigned MASK_MAX_W = tmh_pkg::MaskMaxWDef,
  parameter int unsigned MASK_MAX_H = tmh_pkg::MaskMaxHDef,
  parameter int unsigned MAX_LINE   = tmh_pkg::MaxLineDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmh_pkg::RegAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output tmh_pkg::tmh_cfg_t             cfg_o
);
  import tmh_pkg::*;

  localparam int unsigned MwLim = (MASK_MAX_W > 255) ? 255 : MASK_MAX_W;
  localparam int unsigned MhLim = (MASK_MAX_H > 255) ? 255 : MASK_MAX_H;
  localparam int unsigned LwLim = (MAX_LINE > 32767) ? 32767 : MAX_LINE;
  localparam int unsigned FhLim = FrameLimit;
  localparam int unsigned MwRst = (MwLim < 128) ? MwLim : 128;
  localparam int unsigned MhRst = (MhLim < 128) ? MhLim : 128;
  localparam int unsigned LwRst = (LwLim < 1024) ? LwLim : 1024;
  localparam int unsigned FhRst = (FhLim < 1024) ? FhLim : 1024;

  tmh_cfg_t   cfg_q;
  tmh_cfg_t   cfg_d;
  logic       wr_en;
  logic [1:0] idx;
  logic [7:0] v8;
  logic [14:0] v15;
  logic [7:0] mw_sat;
  logic [7:0] mh_sat;
  logic [14:0] lw_sat;
  logic [14:0] fh_sat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign v8     = pwdata[7:0];
  assign v15    = pwdata[14:0];

  always_comb begin
    mw_sat = (v8 == 8'd0) ? 8'd1 : ((32'(v8) > MwLim) ? 8'(MwLim) : v8);
    mh_sat = (v8 == 8'd0) ? 8'd1 : ((32'(v8) > MhLim) ? 8'(MhLim) : v8);
    lw_sat = (v15 == 15'd0) ? 15'd1 : ((32'(v15) > LwLim) ? 15'(LwLim) : v15);
    fh_sat = (v15 == 15'd0) ? 15'd1 : ((32'(v15) > FhLim) ? 15'(FhLim) : v15);
  end

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegMaskWidth:   cfg_d.mask_width   = mw_sat;
        RegMaskHeight:  cfg_d.mask_height  = mh_sat;
        RegLineWidth:   cfg_d.line_width   = lw_sat;
        RegFrameHeight: cfg_d.frame_height = fh_sat;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_width   <= 8'(MwRst);
      cfg_q.mask_height  <= 8'(MhRst);
      cfg_q.line_width   <= 15'(LwRst);
      cfg_q.frame_height <= 15'(FhRst);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      RegMaskWidth:   prdata = {24'd0, cfg_q.mask_width};
      RegMaskHeight:  prdata = {24'd0, cfg_q.mask_height};
      RegLineWidth:   prdata = {17'd0, cfg_q.line_width};
      RegFrameHeight: prdata = {17'd0, cfg_q.frame_height};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/threshold_mask_halftoner.sv @@
`timescale 1ns / 1ps
// Threshold mask halftoner: 8-bit grey pixels in raster order become packed 1-bit bytes,
// MSB first, one byte per eight pixels and one at each line end, flagged with line and
// frame ends. The threshold mask sits in a single RAM of MASK_MAX_H x MASK_MAX_W bytes
// and is loaded through mask write transfers on the same input channel before pixels are
// sent; entries read before being written give undefined bits. One input transfer is
// taken every clock unless input stalls: a pixel reads its threshold from the RAM in the
// cycle it is taken and is compared in the cycle after; a finished byte then goes to the
// output register. Input stalls only while a finished byte waits behind an unaccepted
// output byte. Register writes through the APB port must happen while the block is idle.
// Depends on tmh_pkg, tmh_pix_if, tmh_byte_if, tmh_ram and tmh_regs.
module threshold_mask_halftoner #(
  parameter int unsigned MASK_MAX_W = tmh_pkg::MaskMaxWDef,
  parameter int unsigned MASK_MAX_H = tmh_pkg::MaskMaxHDef,
  parameter int unsigned MAX_LINE   = tmh_pkg::MaxLineDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tmh_pix_if.sink                      pix_i,
  tmh_byte_if.source                   byte_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmh_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tmh_pkg::*;

  localparam int unsigned Depth = MASK_MAX_W * MASK_MAX_H;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned MCW   = (MASK_MAX_W > 1) ? $clog2(MASK_MAX_W) : 1;
  localparam int unsigned MRW   = (MASK_MAX_H > 1) ? $clog2(MASK_MAX_H) : 1;
  localparam int unsigned LCW   = $clog2(MAX_LINE);

  tmh_cfg_t cfg;

  tmh_regs #(
    .MASK_MAX_W (MASK_MAX_W),
    .MASK_MAX_H (MASK_MAX_H),
    .MAX_LINE   (MAX_LINE)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // position state
  logic [LCW-1:0] col_q, col_d;
  logic [13:0]    row_q, row_d;
  logic [MCW-1:0] mcol_q, mcol_d;
  logic [MRW-1:0] mrow_q, mrow_d;
  logic [2:0]     bcnt_q, bcnt_d;

  // compare stage
  logic           s1_valid_q, s1_valid_d;
  logic [7:0]     s1_pix_q;
  logic [2:0]     s1_idx_q;
  logic           s1_emit_q;
  logic           s1_le_q;
  logic           s1_fe_q;
  logic [7:0]     acc_q, acc_d;

  // output register
  logic           ov_q, ov_d;
  logic [7:0]     ob_q;
  logic           ole_q;
  logic           ofe_q;

  logic           s1_fire;
  logic           stall;
  logic           take;
  logic           take_pix;
  logic           line_done;
  logic           frame_done;
  logic           emit;
  logic           wr_ok;
  logic           ram_we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic [7:0]     thr;
  logic           hit;
  logic [7:0]     byte_val;

  assign s1_fire     = s1_valid_q && (!s1_emit_q || !ov_q || byte_o.ready);
  assign stall       = s1_valid_q && !s1_fire;
  assign pix_i.ready = !stall;
  assign take        = pix_i.valid && !stall;
  assign take_pix    = take && pix_i.action;

  assign wr_ok  = (32'(pix_i.mask_row) < MASK_MAX_H) && (32'(pix_i.mask_col) < MASK_MAX_W);
  assign ram_we = take && !pix_i.action && wr_ok;
  assign waddr  = AW'(32'(pix_i.mask_row) * MASK_MAX_W + 32'(pix_i.mask_col));
  assign raddr  = AW'(32'(mrow_q) * MASK_MAX_W + 32'(mcol_q));

  tmh_ram #(
    .WIDTH (8),
    .DEPTH (Depth)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (pix_i.mask_value),
    .re_i    (take_pix),
    .raddr_i (raddr),
    .rdata_o (thr)
  );

  assign line_done  = (32'(col_q) + 32'd1) >= 32'(cfg.line_width);
  assign frame_done = line_done && ((32'(row_q) + 32'd1) >= 32'(cfg.frame_height));
  assign emit       = (bcnt_q == 3'(BitsPerByte - 1)) || line_done;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    mcol_d = mcol_q;
    mrow_d = mrow_q;
    bcnt_d = bcnt_q;
    if (take_pix) begin
      bcnt_d = emit ? 3'd0 : bcnt_q + 3'd1;
      if (line_done) begin
        col_d  = '0;
        mcol_d = '0;
        if (frame_done) begin
          row_d  = '0;
          mrow_d = '0;
        end else begin
          row_d  = row_q + 14'd1;
          mrow_d = ((32'(mrow_q) + 32'd1) >= 32'(cfg.mask_height)) ? '0 : mrow_q + MRW'(1);
        end
      end else begin
        col_d  = col_q + LCW'(1);
        mcol_d = ((32'(mcol_q) + 32'd1) >= 32'(cfg.mask_width)) ? '0 : mcol_q + MCW'(1);
      end
    end
  end

  assign hit      = (s1_pix_q != 8'd0) && (s1_pix_q >= thr);
  assign byte_val = acc_q | (hit ? bit_weight(s1_idx_q) : 8'd0);

  always_comb begin
    s1_valid_d = s1_valid_q;
    acc_d      = acc_q;
    if (s1_fire) begin
      s1_valid_d = 1'b0;
      acc_d      = s1_emit_q ? 8'd0 : byte_val;
    end
    if (take_pix) begin
      s1_valid_d = 1'b1;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (s1_fire && s1_emit_q) begin
      ov_d = 1'b1;
    end else if (byte_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      mcol_q     <= '0;
      mrow_q     <= '0;
      bcnt_q     <= '0;
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      mcol_q     <= mcol_d;
      mrow_q     <= mrow_d;
      bcnt_q     <= bcnt_d;
      s1_valid_q <= s1_valid_d;
      acc_q      <= acc_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      s1_pix_q  <= pix_i.pixel;
      s1_idx_q  <= bcnt_q;
      s1_emit_q <= emit;
      s1_le_q   <= line_done;
      s1_fe_q   <= frame_done;
    end
    if (s1_fire && s1_emit_q) begin
      ob_q  <= byte_val;
      ole_q <= s1_le_q;
      ofe_q <= s1_fe_q;
    end
  end

  assign byte_o.valid       = ov_q;
  assign byte_o.packed_bits = ob_q;
  assign byte_o.line_end    = ole_q;
  assign byte_o.frame_end   = ofe_q;

endmodule
